### rtl/core/dbu_pkg.sv
// Shared types, constants, ROM contents and helper functions of the double-byte to UTF-8 unit.
package dbu_pkg;

    localparam int TABLE_ENTRIES_DEF     = 20;
    localparam int GLYPH_INDEX_LIMIT_DEF = 2048;
    localparam int ROM_SLOTS             = 64;
    localparam int SEQ_MAX               = 3;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [15:0] CAPACITY_RESET = 16'd256;
    localparam logic [7:0]  ASCII_MASK     = 8'h7f;
    localparam logic [7:0]  LEAD_MIN       = 8'h80;
    localparam logic [7:0]  NUL_BYTE       = 8'h00;
    localparam logic [15:0] UNI_ONE_MAX    = 16'h0080;
    localparam logic [15:0] UNI_TWO_MAX    = 16'h0800;
    localparam logic [7:0]  PFX_TWO        = 8'hc0;
    localparam logic [7:0]  PFX_THREE      = 8'he0;
    localparam logic [7:0]  PFX_CONT       = 8'h80;
    localparam logic [15:0] MASK_6         = 16'h003f;
    localparam logic [15:0] MASK_5         = 16'h001f;
    localparam logic [15:0] MASK_4         = 16'h000f;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [15:0] glyph;
        logic [15:0] big5;
        logic [15:0] uni;
    } t_rom_row;

    typedef struct packed {
        t_byte [SEQ_MAX-1:0] bytes;
        logic [1:0]          count;
        logic                is_end;
    } t_entry;

    function automatic t_rom_row rom_row(input int idx);
        t_rom_row r;
        r = '0;
        case (idx)
            0:       r = '{16'd4,    16'hb943, 16'h904a};
            1:       r = '{16'd5,    16'hc0b8, 16'h6232};
            2:       r = '{16'd14,   16'hc2f7, 16'h96e2};
            3:       r = '{16'd15,   16'hb67d, 16'h958b};
            4:       r = '{16'd51,   16'habd2, 16'h5e1d};
            5:       r = '{16'd68,   16'had6e, 16'h8981};
            6:       r = '{16'd69,   16'hc3b9, 16'h7f85};
            7:       r = '{16'd70,   16'hb0a8, 16'h99ac};
            8:       r = '{16'd71,   16'hb0ea, 16'h570b};
            9:       r = '{16'd72,   16'hb6dc, 16'h55ce};
            10:      r = '{16'd73,   16'ha148, 16'hff1f};
            11:      r = '{16'd80,   16'haaba, 16'h7684};
            12:      r = '{16'd118,  16'ha175, 16'h300c};
            13:      r = '{16'd119,  16'hb3cd, 16'h51f1};
            14:      r = '{16'd120,  16'hbcbb, 16'h6492};
            15:      r = '{16'd121,  16'ha46a, 16'h5927};
            16:      r = '{16'd122,  16'ha176, 16'h300d};
            17:      r = '{16'd297,  16'ha1d0, 16'hff0d};
            18:      r = '{16'd782,  16'hb751, 16'h60f3};
            19:      r = '{16'd1439, 16'ha2bb, 16'h2162};
            default: r = '0;
        endcase
        return r;
    endfunction

    // First matching row wins: scan from the top down so lower rows override.
    function automatic logic [15:0] rom_lookup(input logic [15:0] key, input logic by_glyph,
                                               input int entries);
        logic [15:0] u;
        t_rom_row    r;
        u = '0;
        for (int i = ROM_SLOTS - 1; i >= 0; i--) begin
            r = rom_row(i);
            if (i < entries) begin
                if (by_glyph ? (r.glyph == key) : (r.big5 == key)) begin
                    u = r.uni;
                end
            end
        end
        return u;
    endfunction

    function automatic t_entry utf8_encode(input logic [15:0] u);
        t_entry e;
        e = '0;
        if (u < UNI_ONE_MAX) begin
            e.bytes[0] = u[7:0] & ASCII_MASK;
            e.count    = 2'd1;
        end else if (u < UNI_TWO_MAX) begin
            e.bytes[0] = 8'((u >> 6) & MASK_5) | PFX_TWO;
            e.bytes[1] = 8'(u & MASK_6) | PFX_CONT;
            e.count    = 2'd2;
        end else begin
            e.bytes[0] = 8'((u >> 12) & MASK_4) | PFX_THREE;
            e.bytes[1] = 8'((u >> 6) & MASK_6) | PFX_CONT;
            e.bytes[2] = 8'(u & MASK_6) | PFX_CONT;
            e.count    = 2'd3;
        end
        return e;
    endfunction

endpackage

### rtl/core/dbu_front.sv
// Front end: accepts source bytes, pairs lead bytes, looks up and encodes, checks capacity.
module dbu_front import dbu_pkg::*; #(
    parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
    parameter int GLYPH_INDEX_LIMIT = GLYPH_INDEX_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_entry      o_q_entry
);

    localparam logic [14:0] GLYPH_LIMIT = 15'(GLYPH_INDEX_LIMIT);

    logic [15:0] r_capacity;
    logic [7:0]  r_lead_byte, n_lead_byte;
    logic        r_lead_pending, n_lead_pending;
    logic [15:0] r_bytes_written, n_bytes_written;
    logic        r_full, n_full;

    logic        accept;
    logic [13:0] glyph;
    logic [15:0] big5;
    logic        by_glyph;
    logic [15:0] uni;
    logic [15:0] limit;
    t_entry      seq;
    logic        seq_fits;
    logic        have_seq;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;

    assign glyph    = {i_in_byte[6:0], r_lead_byte[6:0]};
    assign big5     = {r_lead_byte, i_in_byte};
    assign by_glyph = {1'b0, glyph} < GLYPH_LIMIT;
    assign uni      = rom_lookup(by_glyph ? {2'b00, glyph} : big5, by_glyph, TABLE_ENTRIES);
    assign limit    = (r_capacity == 16'd0) ? 16'd0 : r_capacity - 16'd1;
    assign seq_fits = ({1'b0, r_bytes_written} + {15'd0, seq.count}) <= {1'b0, limit};

    always_comb begin
        seq = '0;
        have_seq = 1'b0;
        if (r_lead_pending) begin
            seq      = utf8_encode(uni);
            have_seq = uni != 16'd0;
        end else if (i_in_byte < LEAD_MIN) begin
            seq.bytes[0] = i_in_byte;
            seq.count    = 2'd1;
            have_seq     = 1'b1;
        end
    end

    always_comb begin
        n_lead_byte     = r_lead_byte;
        n_lead_pending  = r_lead_pending;
        n_bytes_written = r_bytes_written;
        n_full          = r_full;
        o_q_push        = 1'b0;
        o_q_entry       = seq;
        if (accept) begin
            if (i_in_byte == NUL_BYTE) begin
                o_q_entry        = '0;
                o_q_entry.count  = 2'd1;
                o_q_entry.is_end = 1'b1;
                o_q_push         = 1'b1;
                n_lead_byte      = '0;
                n_lead_pending   = 1'b0;
                n_bytes_written  = '0;
                n_full           = 1'b0;
            end else if (r_full) begin
                n_lead_pending = 1'b0;
            end else if (!r_lead_pending && i_in_byte >= LEAD_MIN) begin
                n_lead_byte    = i_in_byte;
                n_lead_pending = 1'b1;
            end else begin
                n_lead_pending = 1'b0;
                if (have_seq) begin
                    if (seq_fits) begin
                        o_q_push        = 1'b1;
                        n_bytes_written = r_bytes_written + {14'd0, seq.count};
                    end else begin
                        n_full = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CAPACITY_RESET;
            r_lead_byte     <= '0;
            r_lead_pending  <= 1'b0;
            r_bytes_written <= '0;
            r_full          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            r_lead_byte     <= n_lead_byte;
            r_lead_pending  <= n_lead_pending;
            r_bytes_written <= n_bytes_written;
            r_full          <= n_full;
        end
    end

`ifndef SYNTH
    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_byte == NUL_BYTE |=> r_bytes_written == 16'd0 && !r_full
            && !r_lead_pending)
        else $error("state not cleared after terminator");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && r_full |-> o_q_entry.is_end)
        else $error("content pushed while buffer full");
`endif

endmodule

### rtl/core/dbu_queue.sv
// Two-entry queue of encoded sequences between front and back end.
module dbu_queue import dbu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

### rtl/core/dbu_back.sv
// Back end: serializes queued sequences into output bytes through an output register.
module dbu_back import dbu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_end
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_last;
    logic       r_string_end;

    logic       slot_free;
    logic       load;
    logic       is_last;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign load      = slot_free && !i_q_empty;
    assign is_last   = r_idx == (i_q_entry.count - 2'd1);
    assign o_q_pop   = load && is_last;
    assign n_idx     = is_last ? 2'd0 : r_idx + 2'd1;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_string_end;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= i_q_entry.bytes[r_idx];
            r_run_last   <= is_last;
            r_string_end <= i_q_entry.is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= n_idx;
            end
            if (slot_free) begin
                r_out_valid <= !i_q_empty;
            end
        end
    end

`ifndef SYNTH
    a_end_is_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_string_end |-> r_run_last && r_out_byte == NUL_BYTE)
        else $error("terminator not a lone zero byte");
`endif

endmodule

### rtl/core/double_byte_to_utf8_stream_unit.sv
// Top level of the double-byte to UTF-8 stream converter.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_in_byte
//   out      source     o_out_valid / i_out_stall o_out_byte, o_run_last, o_string_end
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (output capacity)
//
// One source byte is taken per cycle while the two-entry sequence queue has room.
// The back end sends one UTF-8 byte per cycle from its output register unless the
// output stalls, so a character is sent as its 1 to 3 encoded bytes and the output
// port sets the rate. Reset is synchronous, active low, and clears the control
// state but not the queue storage or output data; output capacity returns to 256.
// A stall on the output fills the queue, and then the input stalls.
module double_byte_to_utf8_stream_unit import dbu_pkg::*; #(
    parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
    parameter int GLYPH_INDEX_LIMIT = GLYPH_INDEX_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_string_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_entry q_in_entry;
    t_entry q_out_entry;

    dbu_front #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .GLYPH_INDEX_LIMIT (GLYPH_INDEX_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_in_entry)
    );

    dbu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_out_entry)
    );

    dbu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_entry    (q_out_entry),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule
